// ----- hdl/fxa_pkg.sv -----
package fxa_pkg;

    // number format
    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;

    // divider widths: numerator is 2*(|a| << FRAC_BITS) + |b|, divisor is 2*|b|
    localparam int NUM_W = DATA_W + FRAC_BITS + 1;
    localparam int DEN_W = DATA_W + 1;
    localparam int REM_W = DEN_W;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_FROM_INT = 4'd9
    } t_op;

    // per-transaction control and early result carried down the pipe
    typedef struct packed {
        t_op                op;
        logic               neg;
        logic               dz;
        logic               gt;
        logic               lt;
        logic               eq;
        logic [DATA_W-1:0]  res;
    } t_ctl;

    // one divider stage record
    typedef struct packed {
        t_ctl               ctl;
        logic [REM_W-1:0]   rem;
        logic [NUM_W-1:0]   nq;
        logic [DEN_W-1:0]   den;
    } t_div;

endpackage

// ----- hdl/fxa_front.sv -----
module fxa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_rdy,
    input  logic [3:0]                  i_op,
    input  logic signed [31:0]          i_operand_a,
    input  logic signed [31:0]          i_operand_b,
    output logic                        o_valid,
    input  logic                        i_next_rdy,
    output fxa_pkg::t_div               o_data
);

    // stage 0: decode, compare, simple ops, magnitudes
    logic                               r_v0;
    fxa_pkg::t_ctl                      r_c0;
    logic [fxa_pkg::DATA_W-1:0]         r_mag_a;
    logic [fxa_pkg::DATA_W-1:0]         r_mag_b;
    fxa_pkg::t_ctl                      n_c0;
    logic [fxa_pkg::DATA_W-1:0]         n_mag_a;
    logic [fxa_pkg::DATA_W-1:0]         n_mag_b;
    logic [fxa_pkg::DATA_W-1:0]         w_ua;
    logic [fxa_pkg::DATA_W-1:0]         w_ub;

    // stage 1: product and divider operands
    logic                               r_v1;
    fxa_pkg::t_ctl                      r_c1;
    logic [2*fxa_pkg::DATA_W-1:0]       r_prod;
    logic [fxa_pkg::NUM_W-1:0]          r_num;
    logic [fxa_pkg::DEN_W-1:0]          r_den;

    // stage 2: product rounding, divider record
    logic                               r_v2;
    fxa_pkg::t_div                      r_d2;
    fxa_pkg::t_div                      n_d2;
    logic [fxa_pkg::DATA_W+fxa_pkg::FRAC_BITS-1:0] w_psum;

    logic w_rdy0;
    logic w_rdy1;
    logic w_rdy2;

    assign w_rdy2 = !r_v2 || i_next_rdy;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign o_rdy  = w_rdy0;

    assign w_ua = i_operand_a;
    assign w_ub = i_operand_b;

    always_comb begin
        n_c0.op  = fxa_pkg::t_op'(i_op);
        n_c0.gt  = i_operand_a > i_operand_b;
        n_c0.lt  = i_operand_a < i_operand_b;
        n_c0.eq  = i_operand_a == i_operand_b;
        n_c0.neg = w_ua[31] ^ w_ub[31];
        n_c0.dz  = (n_c0.op == fxa_pkg::OP_DIV) && (w_ub == '0);
        case (n_c0.op)
            fxa_pkg::OP_ADD:      n_c0.res = w_ua + w_ub;
            fxa_pkg::OP_SUB:      n_c0.res = w_ua - w_ub;
            fxa_pkg::OP_MIN:      n_c0.res = n_c0.lt ? w_ua : w_ub;
            fxa_pkg::OP_MAX:      n_c0.res = n_c0.gt ? w_ua : w_ub;
            fxa_pkg::OP_INC:      n_c0.res = w_ua + 32'd1;
            fxa_pkg::OP_DEC:      n_c0.res = w_ua - 32'd1;
            fxa_pkg::OP_TO_INT:   n_c0.res = 32'(i_operand_a >>> fxa_pkg::FRAC_BITS);
            fxa_pkg::OP_FROM_INT: n_c0.res = w_ua << fxa_pkg::FRAC_BITS;
            default:              n_c0.res = '0;
        endcase
        n_mag_a = w_ua[31] ? (~w_ua + 32'd1) : w_ua;
        n_mag_b = w_ub[31] ? (~w_ub + 32'd1) : w_ub;
    end

    // round half away from zero: add half an lsb before dropping the fraction
    assign w_psum = r_prod[fxa_pkg::DATA_W+fxa_pkg::FRAC_BITS-1:0]
                  + ((fxa_pkg::DATA_W+fxa_pkg::FRAC_BITS)'(1) << (fxa_pkg::FRAC_BITS - 1));

    always_comb begin
        n_d2.ctl = r_c1;
        if (r_c1.op == fxa_pkg::OP_MUL) begin
            n_d2.ctl.res = w_psum[fxa_pkg::DATA_W+fxa_pkg::FRAC_BITS-1:fxa_pkg::FRAC_BITS];
        end
        n_d2.rem = '0;
        n_d2.nq  = r_num;
        n_d2.den = r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_c0    <= n_c0;
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
        end
        if (w_rdy1) begin
            r_c1   <= r_c0;
            r_prod <= (2*fxa_pkg::DATA_W)'(r_mag_a) * (2*fxa_pkg::DATA_W)'(r_mag_b);
            r_num  <= {r_mag_a, {(fxa_pkg::FRAC_BITS+1){1'b0}}}
                    + fxa_pkg::NUM_W'(r_mag_b);
            r_den  <= {r_mag_b, 1'b0};
        end
        if (w_rdy2) begin
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_d2;

endmodule

// ----- hdl/fxa_div_step.sv -----
module fxa_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_rdy,
    input  fxa_pkg::t_div   i_data,
    output logic            o_valid,
    input  logic            i_next_rdy,
    output fxa_pkg::t_div   o_data
);

    logic                           r_valid;
    fxa_pkg::t_div                  r_data;
    fxa_pkg::t_div                  n_data;
    logic [fxa_pkg::REM_W:0]        w_trial;
    logic [fxa_pkg::REM_W:0]        w_diff;
    logic                           w_ge;

    assign o_rdy = !r_valid || i_next_rdy;

    // one restoring step: bring down the next numerator bit, try the divisor
    assign w_trial = {i_data.rem, i_data.nq[fxa_pkg::NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_data.den};
    assign w_diff  = w_trial - {1'b0, i_data.den};

    always_comb begin
        n_data     = i_data;
        n_data.rem = w_ge ? w_diff[fxa_pkg::REM_W-1:0] : w_trial[fxa_pkg::REM_W-1:0];
        n_data.nq  = {i_data.nq[fxa_pkg::NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/fixed_point_alu_q24_8_unit.sv -----
// signed fixed-point alu on 32-bit raw words with FRAC_BITS (8) fraction bits.
// one transaction carries an op code and two operands and yields one result with
// a divide-by-zero flag and exact greater/less/equal flags of the raw operands.
// add, sub, min, max, inc, dec, to-integer and from-integer wrap to 32 bits;
// mul and div are exact and round half away from zero before wrapping; divide
// by zero gives 0 with the flag set, and undefined op codes give 0.
// a new transaction is accepted every clock cycle unless o_stall is high; the
// restoring divider resolves one quotient bit per pipeline stage over
// FRAC_BITS + 33 stages. every operation travels the same path so results
// leave in order. empty stages close up under output stall, so input keeps
// flowing until the pipe is full.
module fixed_point_alu_q24_8_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transaction
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [3:0]          i_op,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    // result transaction
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_result,
    output logic                o_div_by_zero,
    output logic                o_a_greater,
    output logic                o_a_less,
    output logic                o_a_equal
);

    // chain of divider stages: index 0 is the front end output
    fxa_pkg::t_div  w_d [fxa_pkg::NUM_W+1];
    logic           w_v [fxa_pkg::NUM_W+1];
    logic           w_r [fxa_pkg::NUM_W+1];
    logic           w_front_rdy;

    // output register
    logic                           r_valid;
    logic [fxa_pkg::DATA_W-1:0]     r_result;
    logic                           r_dz;
    logic                           r_gt;
    logic                           r_lt;
    logic                           r_eq;
    logic [fxa_pkg::DATA_W-1:0]     n_result;
    logic [fxa_pkg::DATA_W-1:0]     w_mag;
    logic [fxa_pkg::DATA_W-1:0]     w_signed_mag;
    fxa_pkg::t_ctl                  w_ctl;
    logic                           w_out_rdy;

    assign o_stall = !w_front_rdy;

    // decode, compare, simple ops, multiply with rounding, divider set-up
    fxa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_rdy       (w_front_rdy),
        .i_op        (i_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (w_v[0]),
        .i_next_rdy  (w_r[0]),
        .o_data      (w_d[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < fxa_pkg::NUM_W; g++) begin : g_div
        fxa_div_step u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_v[g]),
            .o_rdy      (w_r[g]),
            .i_data     (w_d[g]),
            .o_valid    (w_v[g+1]),
            .i_next_rdy (w_r[g+1]),
            .o_data     (w_d[g+1])
        );
    end

    assign w_out_rdy             = !r_valid || !i_stall;
    assign w_r[fxa_pkg::NUM_W]   = w_out_rdy;
    assign w_ctl                 = w_d[fxa_pkg::NUM_W].ctl;

    // mul carries its rounded magnitude in the control word; div takes the
    // low quotient bits, both then get the sign of a xor b
    assign w_mag        = (w_ctl.op == fxa_pkg::OP_DIV)
                        ? w_d[fxa_pkg::NUM_W].nq[fxa_pkg::DATA_W-1:0] : w_ctl.res;
    assign w_signed_mag = w_ctl.neg ? (~w_mag + 32'd1) : w_mag;

    always_comb begin
        case (w_ctl.op)
            fxa_pkg::OP_MUL: n_result = w_signed_mag;
            fxa_pkg::OP_DIV: n_result = w_ctl.dz ? '0 : w_signed_mag;
            default:         n_result = w_ctl.res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_valid <= w_v[fxa_pkg::NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_result <= n_result;
            r_dz     <= w_ctl.dz;
            r_gt     <= w_ctl.gt;
            r_lt     <= w_ctl.lt;
            r_eq     <= w_ctl.eq;
        end
    end

    assign o_valid       = r_valid;
    assign o_result      = r_result;
    assign o_div_by_zero = r_dz;
    assign o_a_greater   = r_gt;
    assign o_a_less      = r_lt;
    assign o_a_equal     = r_eq;

endmodule

// ----- test/fixed_point_alu_q24_8_unit_tb.sv -----
module fixed_point_alu_q24_8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // highest op code the 4-bit field can carry; codes above OP_FROM_INT are undefined
    localparam logic [3:0] OP_LAST_CODE = 4'hF;
    localparam int RANDOM_ITEMS = 1200;
    // no idling on either side once this few transactions are left to send
    localparam int QUIET_TAIL   = 150;
    // receiver hold-off long enough to fill the 45-deep pipe several times over
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 300;
    // keep running after the last expected result so a stray result is caught
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0000_0100;

    // one input transaction
    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_req;

    // one result transaction
    typedef struct {
        logic signed [31:0] result;
        logic               dz;
        logic               gt;
        logic               lt;
        logic               eq;
    } t_alu_res;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [3:0]         i_op        = fxa_pkg::OP_ADD;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic signed [31:0] o_result;
    logic               o_div_by_zero;
    logic               o_a_greater;
    logic               o_a_less;
    logic               o_a_equal;

    fixed_point_alu_q24_8_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result),
        .o_div_by_zero (o_div_by_zero),
        .o_a_greater   (o_a_greater),
        .o_a_less      (o_a_less),
        .o_a_equal     (o_a_equal)
    );

    // stimulus waiting to be sent and results waiting to arrive
    t_alu_req alu_reqs[$];
    t_alu_res expected_results[$];

    int       total_items  = 0;
    int       accepted_cnt = 0;
    int       fail_cnt     = 0;
    int       cycle_cnt    = 0;
    logic     in_taken     = 1'b0;   // transaction on the input was taken at the last edge
    logic     calm_window  = 1'b0;   // stretch with no idling on either side
    int       send_gap     = 0;
    int       stall_left   = 0;
    logic     drain_hold   = 1'b0;
    logic     hold_done    = 1'b0;
    int       hold_cnt     = 0;
    t_alu_req next_req;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact fixed-point behaviour: 64-bit magnitudes, round half away from zero, wrap to 32
    function automatic t_alu_res predict_alu(logic [3:0] op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_res           r;
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic [63:0]        mag_a;
        logic [63:0]        mag_b;
        logic [63:0]        mag_res;
        logic               neg;
        wa      = 64'(a);
        wb      = 64'(b);
        mag_a   = wa[63] ? -wa : wa;
        mag_b   = wb[63] ? -wb : wb;
        neg     = a[31] ^ b[31];
        r.dz    = 1'b0;
        r.gt    = a > b;
        r.lt    = a < b;
        r.eq    = a == b;
        r.result = '0;
        case (op)
            fxa_pkg::OP_ADD:      r.result = a + b;
            fxa_pkg::OP_SUB:      r.result = a - b;
            fxa_pkg::OP_MUL: begin
                mag_res  = (mag_a * mag_b + (64'd1 << (fxa_pkg::FRAC_BITS - 1)))
                           >> fxa_pkg::FRAC_BITS;
                r.result = neg ? ~mag_res[31:0] + 32'd1 : mag_res[31:0];
            end
            fxa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    mag_res  = (2 * (mag_a << fxa_pkg::FRAC_BITS) + mag_b) / (2 * mag_b);
                    r.result = neg ? ~mag_res[31:0] + 32'd1 : mag_res[31:0];
                end
            end
            fxa_pkg::OP_MIN:      r.result = (a < b) ? a : b;
            fxa_pkg::OP_MAX:      r.result = (a > b) ? a : b;
            fxa_pkg::OP_INC:      r.result = a + 32'sd1;
            fxa_pkg::OP_DEC:      r.result = a - 32'sd1;
            fxa_pkg::OP_TO_INT:   r.result = a >>> fxa_pkg::FRAC_BITS;
            fxa_pkg::OP_FROM_INT: r.result = a << fxa_pkg::FRAC_BITS;
            default:              r.result = '0;
        endcase
        return r;
    endfunction

    task automatic add_req(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
        t_alu_req q;
        q.op = op;
        q.a  = a;
        q.b  = b;
        alu_reqs.push_back(q);
    endtask

    // operands spread over full range, small values, whole numbers and the extremes
    function automatic logic signed [31:0] rand_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $signed($urandom_range(0, 8191)) - 32'sd4096;
            1: v = ($signed($urandom_range(0, 2047)) - 32'sd1024) <<< fxa_pkg::FRAC_BITS;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // result side and input capture share one process so the queue sees one order
    always @(posedge i_clk) begin
        t_alu_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result transaction with nothing expected, result %0d",
                         $time, o_result);
                fail_cnt++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result !== exp_res.result) begin
                    $display("%0t: result expected %0d got %0d",
                             $time, exp_res.result, o_result);
                    fail_cnt++;
                end
                if (o_div_by_zero !== exp_res.dz) begin
                    $display("%0t: div_by_zero expected %0b got %0b",
                             $time, exp_res.dz, o_div_by_zero);
                    fail_cnt++;
                end
                if (o_a_greater !== exp_res.gt) begin
                    $display("%0t: a_greater expected %0b got %0b",
                             $time, exp_res.gt, o_a_greater);
                    fail_cnt++;
                end
                if (o_a_less !== exp_res.lt) begin
                    $display("%0t: a_less expected %0b got %0b",
                             $time, exp_res.lt, o_a_less);
                    fail_cnt++;
                end
                if (o_a_equal !== exp_res.eq) begin
                    $display("%0t: a_equal expected %0b got %0b",
                             $time, exp_res.eq, o_a_equal);
                    fail_cnt++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(predict_alu(i_op, i_operand_a, i_operand_b));
            accepted_cnt++;
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // driver: holds a stalled transaction, otherwise sends the next one or idles in bursts
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (alu_reqs.size() == 0) begin
                i_valid <= 1'b0;
            end else if (!calm_window && alu_reqs.size() > QUIET_TAIL
                         && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 17);
                i_valid <= 1'b0;
            end else begin
                next_req = alu_reqs.pop_front();
                i_valid     <= 1'b1;
                i_op        <= next_req.op;
                i_operand_a <= next_req.a;
                i_operand_b <= next_req.b;
            end
        end
    end

    // receiver stall: random bursts, plus the long hold-off that backs up the pipe
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (drain_hold) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm_window && alu_reqs.size() > QUIET_TAIL
                     && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // long hold-off, counted in its own process, while the sender keeps offering
    always @(posedge i_clk) begin
        if (!hold_done && !drain_hold && accepted_cnt >= HOLD_START) begin
            drain_hold <= 1'b1;
            hold_cnt   <= 0;
        end else if (drain_hold) begin
            if (hold_cnt == HOLD_CYCLES) begin
                drain_hold <= 1'b0;
                hold_done  <= 1'b1;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end
    end

    // cycle counter: picks calm windows and ends a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 128 == 0)
            calm_window <= ($urandom_range(0, 3) == 0);
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;

        // directed: wrap on add and sub
        add_req(fxa_pkg::OP_ADD, Q_MAX, Q_MAX);
        add_req(fxa_pkg::OP_SUB, Q_MIN, 32'sd1);
        // mul: exact halves round away from zero, largest magnitudes
        add_req(fxa_pkg::OP_MUL, 32'sd1, 32'sd128);
        add_req(fxa_pkg::OP_MUL, -32'sd1, 32'sd128);
        add_req(fxa_pkg::OP_MUL, Q_MAX, Q_MAX);
        add_req(fxa_pkg::OP_MUL, Q_MIN, Q_MIN);
        add_req(fxa_pkg::OP_MUL, Q_MIN, -Q_ONE);
        // div: by zero, largest quotient, rounding, zero numerator
        add_req(fxa_pkg::OP_DIV, Q_ONE, '0);
        add_req(fxa_pkg::OP_DIV, '0, '0);
        add_req(fxa_pkg::OP_DIV, Q_MIN, -32'sd1);
        add_req(fxa_pkg::OP_DIV, Q_MAX, 32'sd1);
        add_req(fxa_pkg::OP_DIV, Q_ONE, 3 * Q_ONE);
        add_req(fxa_pkg::OP_DIV, -Q_ONE, 32'sd512);
        add_req(fxa_pkg::OP_DIV, Q_MIN, Q_MIN);
        add_req(fxa_pkg::OP_DIV, '0, Q_MIN);
        // min and max, equal operands pick operand b
        add_req(fxa_pkg::OP_MIN, Q_MIN, Q_MAX);
        add_req(fxa_pkg::OP_MAX, Q_MIN, Q_MAX);
        add_req(fxa_pkg::OP_MAX, 32'sd5, 32'sd5);
        // inc and dec wrap, compare flags on unary ops
        add_req(fxa_pkg::OP_INC, Q_MAX, Q_MIN);
        add_req(fxa_pkg::OP_DEC, Q_MIN, Q_MAX);
        // to_int floors toward minus infinity
        add_req(fxa_pkg::OP_TO_INT, -32'sd1, -32'sd1);
        add_req(fxa_pkg::OP_TO_INT, Q_MIN, 32'sd0);
        add_req(fxa_pkg::OP_FROM_INT, Q_MAX, Q_ONE);
        // undefined op codes
        add_req(4'(fxa_pkg::OP_FROM_INT + 1), Q_MAX, 32'sd3);
        add_req(OP_LAST_CODE, Q_MIN, Q_MIN);

        // random: mostly defined ops, some equal operands, a few undefined codes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 15) == 0)
                op = 4'($urandom_range(fxa_pkg::OP_FROM_INT + 1, OP_LAST_CODE));
            else
                op = 4'($urandom_range(fxa_pkg::OP_ADD, fxa_pkg::OP_FROM_INT));
            a = rand_operand();
            b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
            add_req(op, a, b);
        end
        total_items = alu_reqs.size();

        // hold synchronous reset, then release it at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
